FILE: rtl/core/pqck_pkg.sv
package pqck_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_PEEK   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_COUNT  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int KEY_W = 60;
  localparam int TAG_W = 16;

  // key: inverted rank, year, month, day, arrival stamp from msb down
  typedef struct packed {
    logic [2:0]  inv_rank;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [31:0] stamp;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [15:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/pqck_ram.sv
module pqck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/priority_queue_composite_key.sv
// priority queue over a binary max-heap held in one single-read-port ram
// in channel: in_tuser carries the request (insert, peek, remove, count),
//   in_tdata the entry to insert; one request is taken at a time
// out channel: one beat per request, status in out_tuser, count and the
//   top entry (peeked or removed) in out_tdata
// priority: lower class rank, then newer date, then later arrival stamp
// request steps: count and refused requests go straight to the result; peek
//   reads the top entry; remove reads the top and, unless it was the last
//   entry, the last one, which it walks down from the root; insert walks the
//   new entry up from the end of the heap; each walk ends by writing the
//   walked entry into its slot, before the result is registered
// one shared key comparator serves both walks; a climbed level costs one
//   ram read, one compare and one ram write, a descended one up to two reads
// the result sits in an output register; while the receiver stalls the
//   block finishes its work and holds until that register is free
// reset empties the queue and zeroes the arrival stamp; the ram itself is
//   not cleared, there is no clearing pass
module priority_queue_composite_key #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // class_rank, year_in, month_in, day_in, tag_in
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // count, top_rank, top_year, top_month, top_day, top_tag
  output logic [1:0]  out_tuser   // status
);

  import pqck_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_TOP    = 4'd3;
  localparam logic [3:0] S_LAST   = 4'd4;
  localparam logic [3:0] S_DN_L   = 4'd5;
  localparam logic [3:0] S_DN_R   = 4'd6;
  localparam logic [3:0] S_DN_C   = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   arr_r, arr_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  entry_t        cur_r, cur_nxt;
  entry_t        best_r, best_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic          has_best_r, has_best_nxt;
  logic [2:0]    top_rank_r, top_rank_nxt;
  logic [15:0]   top_year_r, top_year_nxt;
  logic [3:0]    top_month_r, top_month_nxt;
  logic [4:0]    top_day_r, top_day_nxt;
  logic [15:0]   top_tag_r, top_tag_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [55:0]   out_data_r, out_data_nxt;
  logic [1:0]    out_user_r, out_user_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  logic [AW-1:0] parent;
  logic [LW-1:0] lc, rc, cnt_ext;
  logic [CW+6:0] cnt_wide;
  logic [CW-1:0] cnt_dec;
  logic          cmp_up, cmp_gt;
  key_t          cmp_a, cmp_b;
  key_t          ref_key, new_key;
  logic          out_free;

  pqck_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  assign parent   = AW'((pos_r - AW'(1)) >> 1);
  assign lc       = {1'b0, pos_r, 1'b1};
  assign rc       = lc + LW'(1);
  assign cnt_ext  = LW'(cnt_r);
  assign cnt_dec  = cnt_r - CW'(1);
  assign cnt_wide = {7'd0, cnt_r};
  // climbing compares the new entry against its parent, descending compares
  // a child against the best seen so far at this level
  assign ref_key  = (state_r == S_DN_C && has_best_r) ? best_r.key : cur_r.key;
  assign cmp_up   = (state_r == S_UP_CMP);
  assign cmp_a    = cmp_up ? cur_r.key : ram_rdata.key;
  assign cmp_b    = cmp_up ? ram_rdata.key : ref_key;
  assign cmp_gt   = cmp_a > cmp_b;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    new_key.inv_rank = 3'd7 - in_tdata[2:0];
    new_key.year     = in_tdata[18:3];
    new_key.month    = in_tdata[22:19];
    new_key.day      = in_tdata[27:23];
    new_key.stamp    = arr_r;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    arr_nxt        = arr_r;
    pos_nxt        = pos_r;
    mode_nxt       = mode_r;
    res_status_nxt = res_status_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    has_best_nxt   = has_best_r;
    top_rank_nxt   = top_rank_r;
    top_year_nxt   = top_year_r;
    top_month_nxt  = top_month_r;
    top_day_nxt    = top_day_r;
    top_tag_nxt    = top_tag_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = cur_r;
    ram_raddr      = '0;
    in_tready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt       = in_tuser;
          res_status_nxt = ST_OK;
          top_rank_nxt   = '0;
          top_year_nxt   = '0;
          top_month_nxt  = '0;
          top_day_nxt    = '0;
          top_tag_nxt    = '0;
          state_nxt      = S_DONE;
          unique case (in_tuser)
            MODE_INSERT: begin
              if (cnt_ext >= LW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                cur_nxt.key = new_key;
                cur_nxt.tag = in_tdata[43:28];
                pos_nxt     = cnt_r[AW-1:0];
                cnt_nxt     = cnt_r + CW'(1);
                arr_nxt     = arr_r + 32'd1;
                state_nxt   = (cnt_r == '0) ? S_WR : S_UP_RD;
              end
            end
            MODE_PEEK, MODE_REMOVE: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_TOP;
              end
            end
            MODE_COUNT: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_UP_RD: begin
        ram_raddr = parent;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (cmp_gt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = parent;
          state_nxt = (parent == '0) ? S_WR : S_UP_RD;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_TOP: begin
        top_rank_nxt  = 3'd7 - ram_rdata.key.inv_rank;
        top_year_nxt  = ram_rdata.key.year;
        top_month_nxt = ram_rdata.key.month;
        top_day_nxt   = ram_rdata.key.day;
        top_tag_nxt   = ram_rdata.tag;
        state_nxt     = S_DONE;
        if (mode_r == MODE_REMOVE) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec != '0) begin
            ram_raddr = cnt_dec[AW-1:0];
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        cur_nxt   = ram_rdata;
        pos_nxt   = '0;
        state_nxt = S_DN_L;
      end
      S_DN_L: begin
        if (lc >= cnt_ext) begin
          state_nxt = S_WR;
        end else begin
          ram_raddr = lc[AW-1:0];
          state_nxt = S_DN_R;
        end
      end
      S_DN_R: begin
        if (rc < cnt_ext) begin
          best_nxt     = ram_rdata;
          best_idx_nxt = lc[AW-1:0];
          has_best_nxt = cmp_gt;
          ram_raddr    = rc[AW-1:0];
          state_nxt    = S_DN_C;
        end else if (cmp_gt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = lc[AW-1:0];
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_DN_C: begin
        priority if (cmp_gt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = rc[AW-1:0];
          state_nxt = S_DN_L;
        end else if (has_best_r) begin
          ram_we    = 1'b1;
          ram_wdata = best_r;
          pos_nxt   = best_idx_r;
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {5'd0, top_tag_r, top_day_r, top_month_r, top_year_r,
                           top_rank_r, cnt_wide[6:0]};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      arr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      arr_r       <= arr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    mode_r       <= mode_nxt;
    res_status_r <= res_status_nxt;
    cur_r        <= cur_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    has_best_r   <= has_best_nxt;
    top_rank_r   <= top_rank_nxt;
    top_year_r   <= top_year_nxt;
    top_month_r  <= top_month_nxt;
    top_day_r    <= top_day_nxt;
    top_tag_r    <= top_tag_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: tb/priority_queue_composite_key_test.sv
`timescale 1ns / 1ps

module priority_queue_composite_key_test;
  import pqck_pkg::*;

  localparam int DEPTH = 64;

  // laid out as status on top of the used bits of out_tdata
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [2:0]  rank;
    logic [6:0]  count;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // class_rank, year_in, month_in, day_in, tag_in
  logic [1:0]  in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // count, top_rank, top_year, top_month, top_day, top_tag
  logic [1:0]  out_tuser;  // status

  priority_queue_composite_key u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // heap mirror
  key_t        heap_key [DEPTH];
  logic [15:0] heap_tag [DEPTH];
  int          held;
  logic [31:0] stamp_next;

  reply_t replies_due[$];
  int     mismatches;
  int     out_gap;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void swap_slots(int i, int j);
    key_t        k;
    logic [15:0] t;
    k = heap_key[i]; t = heap_tag[i];
    heap_key[i] = heap_key[j]; heap_tag[i] = heap_tag[j];
    heap_key[j] = k; heap_tag[j] = t;
  endfunction

  function automatic reply_t queue_apply(logic [1:0] mode, logic [2:0] rank,
      logic [15:0] year, logic [3:0] month, logic [4:0] day, logic [15:0] tag);
    reply_t r;
    int     pos;
    int     up;
    int     best;
    r = '0;
    r.status = ST_OK;
    if (mode == MODE_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = held;
        heap_key[pos] = '{inv_rank: 3'd7 - rank, year: year, month: month, day: day,
                          stamp: stamp_next};
        heap_tag[pos] = tag;
        stamp_next++;
        held++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_key[pos] > heap_key[up]) begin
            swap_slots(pos, up);
            pos = up;
          end else break;
        end
      end
    end else if (mode == MODE_PEEK || mode == MODE_REMOVE) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.rank  = 3'd7 - heap_key[0].inv_rank;
        r.year  = heap_key[0].year;
        r.month = heap_key[0].month;
        r.day   = heap_key[0].day;
        r.tag   = heap_tag[0];
        if (mode == MODE_REMOVE) begin
          held--;
          heap_key[0] = heap_key[held];
          heap_tag[0] = heap_tag[held];
          pos = 0;
          forever begin
            best = pos;
            if (2*pos+1 < held && heap_key[2*pos+1] > heap_key[best]) best = 2*pos+1;
            if (2*pos+2 < held && heap_key[2*pos+2] > heap_key[best]) best = 2*pos+2;
            if (best == pos) break;
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    r.count = held[6:0];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // valid stays up after a beat and is dropped by the next call when it waits a gap, or by a drain
  task automatic send_request(logic [1:0] mode, logic [2:0] rank, logic [15:0] year,
      logic [3:0] month, logic [4:0] day, logic [15:0] tag, bit with_gaps = 1);
    int g;
    g = with_gaps ? gap_len() : 0;
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'd0, tag, day, month, year, rank};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replies_due.push_back(queue_apply(mode, rank, year, month, day, tag));
  endtask

  task automatic send_random(int ins_weight);
    logic [1:0] mode;
    int         p;
    p = $urandom_range(0, 99);
    if (p < ins_weight) mode = MODE_INSERT;
    else mode = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 9) == 0) mode = 2'($urandom_range(0, 3));
    // narrow years make ties on the year frequent, so month, day and stamp decide
    send_request(mode, 3'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                   : $urandom_range(0, 4)),
                 $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(2020, 2022)),
                 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)), 16'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // receiver side: after each beat a random pause, mostly short
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (out_gap != 0) begin
      out_tready <= 1'b0;
      out_gap    <= out_gap - 1;
    end else if (out_tvalid && out_tready) begin
      g = gap_len();
      out_tready <= (g == 0);
      out_gap    <= (g == 0) ? 0 : g - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[50:0]};
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"beat mismatch: expected st=%0d cnt=%0d r=%0d %0d-%0d-%0d tag=%h,",
                      " got st=%0d cnt=%0d r=%0d %0d-%0d-%0d tag=%h"},
                     want.status, want.count, want.rank, want.year, want.month,
                     want.day, want.tag,
                     got.status, got.count, got.rank, got.year, got.month, got.day,
                     got.tag);
        end
      end
    end
  end

  task automatic test_empty();
    send_request(MODE_PEEK, 0, 0, 0, 0, 0);
    send_request(MODE_REMOVE, 0, 0, 0, 0, 0);
    send_request(MODE_COUNT, 0, 0, 0, 0, 0);
  endtask

  task automatic test_extremes();
    send_request(MODE_INSERT, 3'd4, 16'hffff, 4'd12, 5'd31, 16'hffff);
    send_request(MODE_INSERT, 3'd0, 16'h0000, 4'd1, 5'd1, 16'h0000);
    send_request(MODE_INSERT, 3'd7, 16'hffff, 4'd15, 5'd31, 16'haaaa);
    send_request(MODE_INSERT, 3'd0, 16'h0000, 4'd0, 5'd0, 16'h5555);
    send_request(MODE_INSERT, 3'd0, 16'h0000, 4'd1, 5'd1, 16'h1234);
    send_request(MODE_INSERT, 3'd5, 16'h8000, 4'd6, 5'd15, 16'h8001);
    send_request(MODE_PEEK, 0, 0, 0, 0, 0);
    send_request(MODE_COUNT, 3'd7, 16'hffff, 4'd15, 5'd31, 16'hffff);
    repeat (7) send_request(MODE_REMOVE, 0, 0, 0, 0, 0);
  endtask

  task automatic test_full();
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(MODE_INSERT, 3'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
                   4'($urandom_range(1, 2)), 5'($urandom_range(1, 2)), 16'(i), i < 8);
    send_request(MODE_PEEK, 0, 0, 0, 0, 0);
    repeat (DEPTH + 1) send_request(MODE_REMOVE, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1900; i++) begin
      send_random((i / 150) % 2 == 0 ? 70 : 35);
      if (i == 950) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_COUNT;
    held = 0;
    stamp_next = '0;
    mismatches = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty();
    test_extremes();
    test_full();
    test_random();
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("priority_queue_composite_key_test passed");
    end else begin
      $display("priority_queue_composite_key_test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("priority_queue_composite_key_test failed");
    $finish;
  end

endmodule

FILE: priority_queue_composite_key.f
rtl/core/pqck_pkg.sv
rtl/core/pqck_ram.sv
rtl/core/priority_queue_composite_key.sv
tb/priority_queue_composite_key_test.sv
